// File: rtl/core/text_console_cursor_engine_top_assert.svh
// Assertion macros for the text console cursor engine.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTH
// Checked while out of reset.
`define TCCE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define TCCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCCE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/tcce_pkg.sv
// Package: geometry, codes, payload types and helpers of the text console engine.
package tcce_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int NCOL_W = $clog2(COLUMNS + TAB_WIDTH);
  localparam int NSTOPS = (COLUMNS + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam int POS_W  = 11;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0]  ATTR_RESET  = 8'h0F;
  localparam logic [15:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        scrolled;
  } out_item_t;

  // Cursor move for one put transaction.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             wr;
    logic             scroll;
  } cur_step_t;

  // Next tab stop above col; stop positions are elaboration constants.
  function automatic logic [NCOL_W-1:0] tab_stop(input logic [COL_W-1:0] col);
    logic [NCOL_W-1:0] r;
    r = NCOL_W'(TAB_WIDTH);
    for (int i = 0; i < NSTOPS; i++) begin
      if (int'(col) >= i * TAB_WIDTH) begin
        r = NCOL_W'((i + 1) * TAB_WIDTH);
      end
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    return ADDR_W'(32'(row) * COLUMNS + 32'(col));
  endfunction

endpackage

// File: rtl/core/tcce_cell_ram.sv
// Cell store: one write port, one registered read port.
module tcce_cell_ram
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wa,
  input  logic [15:0]       wd,
  input  logic              re,
  input  logic [ADDR_W-1:0] ra,
  output logic [15:0]       rdata
);

  logic [15:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[ra];
    end
  end

endmodule

// File: rtl/core/tcce_cursor_step.sv
// Cursor update for a put transaction: control codes, advance, wrap and scroll request.
module tcce_cursor_step
  import tcce_pkg::*;
(
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  input  logic [7:0]       char_code,
  output cur_step_t        step
);

  logic [NCOL_W-1:0] ncol;
  logic              row_inc;

  always_comb begin
    ncol    = NCOL_W'(col);
    row_inc = 1'b0;
    step    = '0;
    unique case (char_code)
      CH_BS: begin
        if (col != '0) ncol = NCOL_W'(col) - NCOL_W'(1);
      end
      CH_TAB: ncol = tab_stop(col);
      CH_CR:  ncol = '0;
      CH_LF: begin
        ncol    = '0;
        row_inc = 1'b1;
      end
      default: begin
        if (char_code >= CH_SPACE) begin
          ncol    = NCOL_W'(col) + NCOL_W'(1);
          step.wr = 1'b1;
        end
      end
    endcase
    if (32'(ncol) >= COLUMNS) begin
      ncol    = '0;
      row_inc = 1'b1;
    end
    step.col = COL_W'(ncol);
    step.row = row;
    if (row_inc) begin
      if (32'(row) == ROWS - 1) step.scroll = 1'b1;
      else step.row = row + ROW_W'(1);
    end
  end

endmodule

// File: rtl/core/text_console_cursor_engine_top.sv
// Top level of the text console engine: sequencer, cursor, attribute and result register.
//
// An 80x25 console whose cells live in one synchronous RAM (one write, one read port).
// After reset the block sweeps the RAM with blank cells (0x0F20), one cell a cycle, over
// all 2000 cells; in_ready stays low meanwhile, while attribute writes on cfg are taken at any
// time. A put that does not scroll and a read go from the transaction cycle, which does the
// RAM write of a printable character or issues the RAM read, to S_DONE, which loads the
// result register once it is empty or being taken. A clear sweeps all 2000 cells. A put
// that scrolls copies 1920 cells up by one row through the RAM read port, writing each
// cell back in the cycle after its read, then blanks the last 80 cells. The result register
// holds a finished result until taken; the next transaction may already be accepted then.
module text_console_cursor_engine_top
  import tcce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  `include "text_console_cursor_engine_top_assert.svh"

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_BLANK  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] swp_r, swp_nxt;
  logic [ADDR_W-1:0] cp_addr_r;
  logic              cp_vld_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [7:0]        attr_r;
  logic [1:0]        op_r, op_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              res_scr_r, res_scr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_acc;
  logic              we, re;
  logic [ADDR_W-1:0] wa, ra;
  logic [15:0]       wd, rdata;
  logic [ADDR_W-1:0] cur_pos;
  cur_step_t         step;

  tcce_cursor_step u_step (
    .col       (col_r),
    .row       (row_r),
    .char_code (in_data.char_code),
    .step      (step)
  );

  tcce_cell_ram u_ram (
    .clk   (clk),
    .we    (we),
    .wa    (wa),
    .wd    (wd),
    .re    (re),
    .ra    (ra),
    .rdata (rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cur_pos   = lin_pos(row_r, col_r);

  // RAM ports: a pending scroll copy owns the write port first.
  always_comb begin
    we = 1'b0;
    wa = swp_r;
    wd = BLANK_RESET;
    re = 1'b0;
    ra = ADDR_W'(swp_r + ADDR_W'(COLUMNS));
    priority if (cp_vld_r) begin
      we = 1'b1;
      wa = cp_addr_r;
      wd = rdata;
    end else if (state_r == S_INIT) begin
      we = 1'b1;
    end else if (state_r == S_BLANK) begin
      we = 1'b1;
      wd = {attr_r, CH_SPACE};
    end else if (in_acc && in_data.opcode == OP_PUT && step.wr) begin
      we = 1'b1;
      wa = cur_pos;
      wd = {attr_r, in_data.char_code};
    end else begin
      we = 1'b0;
    end
    if (state_r == S_SCROLL) begin
      re = 1'b1;
    end else if (in_acc && in_data.opcode == OP_READ) begin
      re = 1'b1;
      ra = ADDR_W'(in_data.cell_address);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    swp_nxt       = swp_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    op_nxt        = op_r;
    rd_ok_nxt     = rd_ok_r;
    res_scr_nxt   = res_scr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_INIT: begin
        swp_nxt = swp_r + ADDR_W'(1);
        if (32'(swp_r) == CELLS - 1) begin
          swp_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_data.opcode;
          rd_ok_nxt   = (32'(in_data.cell_address) < CELLS);
          res_scr_nxt = 1'b0;
          state_nxt   = S_DONE;
          unique case (in_data.opcode)
            OP_PUT: begin
              col_nxt     = step.col;
              row_nxt     = step.row;
              res_scr_nxt = step.scroll;
              if (step.scroll) begin
                swp_nxt   = '0;
                state_nxt = S_SCROLL;
              end
            end
            OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              swp_nxt   = '0;
              state_nxt = S_BLANK;
            end
            default: ;
          endcase
        end
      end
      S_SCROLL: begin
        swp_nxt = swp_r + ADDR_W'(1);
        if (32'(swp_r) == CELLS - COLUMNS - 1) begin
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        if (!cp_vld_r) begin
          swp_nxt = swp_r + ADDR_W'(1);
          if (32'(swp_r) == CELLS - 1) begin
            swp_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.cursor_position = POS_W'(cur_pos);
          out_data_nxt.cell_data       = (op_r == OP_READ && rd_ok_r) ? rdata : 16'h0000;
          out_data_nxt.scrolled        = res_scr_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      swp_r       <= '0;
      cp_vld_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= ATTR_RESET;
      op_r        <= OP_PUT;
      rd_ok_r     <= 1'b0;
      res_scr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      swp_r       <= swp_nxt;
      cp_vld_r    <= (state_r == S_SCROLL);
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      op_r        <= op_nxt;
      rd_ok_r     <= rd_ok_nxt;
      res_scr_r   <= res_scr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) attr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r  <= swp_r;
    out_data_r <= out_data_nxt;
  end

  `TCCE_ASSERT(a_acc_leaves_idle, clk, rst_n, in_acc |=> (state_r != S_IDLE), "accepted transaction did not start work")
  `TCCE_ASSERT(a_scroll_last_row, clk, rst_n, (state_r == S_DONE && res_scr_r) |-> (32'(row_r) == ROWS - 1), "scroll did not leave cursor on last row")
  `TCCE_ASSERT(a_copy_from_scroll, clk, rst_n, cp_vld_r |-> (state_r == S_SCROLL || state_r == S_BLANK), "copy write outside scroll")
  `TCCE_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result appeared without completion")

endmodule

// File: test/tb_text_console_cursor_engine_top.sv
// Testbench for the text console cursor engine: random and directed traffic, scoreboard check.
`timescale 1ns / 100ps

module tb_text_console_cursor_engine_top;
  import tcce_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_data;

  // Shadow copy of the console.
  logic [15:0] screen [CELLS];
  int          cur_col;
  int          cur_row;
  logic [7:0]  attr_reg;

  out_item_t pending_outputs [$];
  int        error_count;
  int        results_seen;
  int        scroll_count;
  int        op_count [4];
  bit        idle_on;

  text_console_cursor_engine_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Apply one transaction to the shadow console and form the result it gives.
  task automatic step_console(input in_item_t it, output out_item_t res);
    logic [15:0] blank;
    bit          rolled;
    res    = '0;
    blank  = {attr_reg, CH_SPACE};
    rolled = 1'b0;
    case (it.opcode)
      OP_PUT: begin
        if (it.char_code == CH_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (it.char_code == CH_TAB) begin
          cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
        end else if (it.char_code == CH_CR) begin
          cur_col = 0;
        end else if (it.char_code == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (it.char_code >= CH_SPACE) begin
          screen[cur_row * COLUMNS + cur_col] = {attr_reg, it.char_code};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = blank;
          cur_row = ROWS - 1;
          rolled  = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = blank;
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ: begin
        if (it.cell_address < CELLS) res.cell_data = screen[it.cell_address];
      end
      default: ;
    endcase
    res.cursor_position = 11'(cur_row * COLUMNS + cur_col);
    res.scrolled        = rolled;
  endtask

  function automatic in_item_t make_item(input logic [1:0] op, input logic [7:0] ch,
                                         input logic [10:0] addr);
    in_item_t it;
    it.opcode       = op;
    it.char_code    = ch;
    it.cell_address = addr;
    return it;
  endfunction

  // Mostly text with control codes, with some clears and unused opcodes; reads lean toward recently written cells.
  function automatic in_item_t random_console_item(input int lf_pct, input int clear_pm);
    in_item_t it;
    int       pick;
    int       addr;
    it.opcode       = OP_PUT;
    it.char_code    = 8'($urandom_range(0, 255));
    it.cell_address = 11'($urandom_range(0, 2047));
    pick = $urandom_range(0, 999);
    if (pick < clear_pm) begin
      it.opcode = OP_CLEAR;
    end else if (pick < clear_pm + 10) begin
      it.opcode = OP_UNUSED;
    end else if (pick < 250) begin
      it.opcode = OP_READ;
      case ($urandom_range(0, 3))
        0: ;
        3: it.cell_address = 11'($urandom_range(0, CELLS - 1));
        default: begin
          addr = cur_row * COLUMNS + cur_col - int'($urandom_range(0, 160));
          if (addr < 0) addr = 0;
          it.cell_address = 11'(addr);
        end
      endcase
    end else if (pick < 250 + lf_pct * 10) begin
      it.char_code = CH_LF;
    end else if (pick < 320 + lf_pct * 10) begin
      case ($urandom_range(0, 4))
        0, 4: it.char_code = CH_BS;
        1: it.char_code = CH_TAB;
        2: it.char_code = CH_CR;
        default: it.char_code = 8'($urandom_range(0, 31));
      endcase
    end else begin
      it.char_code = 8'($urandom_range(CH_SPACE, 255));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t item);
    out_item_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    step_console(item, res);
    pending_outputs.push_back(res);
    op_count[item.opcode]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Attribute changes only with nothing in flight.
  task automatic write_attribute(input logic [7:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    attr_reg = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_contents();
    send_item(make_item(OP_READ, 8'h00, 11'd0));
    send_item(make_item(OP_READ, 8'hFF, 11'(CELLS - 1)));
    send_item(make_item(OP_READ, 8'h55, 11'h7FF));
  endtask

  task automatic test_control_codes();
    send_item(make_item(OP_PUT, 8'h41, 11'h7FF));
    send_item(make_item(OP_PUT, 8'hFF, 11'h000));
    send_item(make_item(OP_PUT, CH_BS, 11'h2AA));
    send_item(make_item(OP_PUT, CH_CR, 11'h555));
    send_item(make_item(OP_PUT, CH_BS, 11'h000));  // already at column 0
    send_item(make_item(OP_PUT, 8'h00, 11'h000));
    send_item(make_item(OP_PUT, 8'h1F, 11'h000));
    send_item(make_item(OP_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047))));
    send_item(make_item(OP_PUT, CH_LF, 11'h000));
    send_item(make_item(OP_READ, 8'h00, 11'd1));
  endtask

  task automatic test_tab_stops();
    repeat (9) send_item(make_item(OP_PUT, CH_TAB, 11'h000));
    send_item(make_item(OP_PUT, 8'h7A, 11'h000));
    send_item(make_item(OP_PUT, CH_TAB, 11'h000));  // off the right edge, wraps
    send_item(make_item(OP_READ, 8'h00, 11'(COLUMNS + 72)));
  endtask

  task automatic test_clear();
    send_item(make_item(OP_CLEAR, 8'hFF, 11'h7FF));
    send_item(make_item(OP_READ, 8'h00, 11'd0));
    send_item(make_item(OP_READ, 8'h00, 11'(COLUMNS + 72)));
  endtask

  task automatic test_scrolling(input int count);
    repeat (count) send_item(random_console_item(20, 0));
  endtask

  task automatic test_random_text(input int count);
    repeat (count) send_item(random_console_item(5, 2));
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) send_item(random_console_item(6, 2));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        report_error("result with no transaction outstanding");
      end else begin
        want = pending_outputs.pop_front();
        if (out_data.cursor_position !== want.cursor_position)
          report_error($sformatf("cursor_position got %0d exp %0d",
                                 out_data.cursor_position, want.cursor_position));
        if (out_data.cell_data !== want.cell_data)
          report_error($sformatf("cell_data got %h exp %h", out_data.cell_data, want.cell_data));
        if (out_data.scrolled !== want.scrolled)
          report_error($sformatf("scrolled got %b exp %b", out_data.scrolled, want.scrolled));
        results_seen++;
        if (want.scrolled) scroll_count++;
      end
    end
  end

  // Result-side back-pressure.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d results outstanding", pending_outputs.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    attr_reg  = ATTR_RESET;
    cur_col   = 0;
    cur_row   = 0;
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_control_codes();
    test_tab_stops();
    write_attribute(8'h00);
    test_clear();
    write_attribute(8'hFF);
    test_scrolling(300);
    write_attribute(8'($urandom_range(0, 255)));
    test_random_text(700);
    write_attribute(8'($urandom_range(0, 255)));
    test_random_text(400);
    write_attribute(8'($urandom_range(0, 255)));
    test_back_to_back(500);

    drain_results();
    repeat (10) @(posedge clk);
    if (pending_outputs.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_outputs.size()));
    $display("covered %0d puts, %0d clears, %0d reads, %0d unused opcodes",
             op_count[OP_PUT], op_count[OP_CLEAR], op_count[OP_READ], op_count[OP_UNUSED]);
    $display("checked %0d results, %0d scrolls, %0d mismatches",
             results_seen, scroll_count, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: text_console_cursor_engine_top.f
+incdir+rtl/core
rtl/core/tcce_pkg.sv
rtl/core/tcce_cell_ram.sv
rtl/core/tcce_cursor_step.sv
rtl/core/text_console_cursor_engine_top.sv
test/tb_text_console_cursor_engine_top.sv
